### hdl/set_assoc_cache_tag_lru_partition_core_macros.svh
// Assertion macros for the cache tag store; they expand to nothing in synthesis.
`ifndef SET_ASSOC_CACHE_TAG_LRU_PARTITION_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LRU_PARTITION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SALC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SALC_ASSERT_SAME(lbl, ante, cons)
`define SALC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/salc_pkg.sv
// Shared types and constants of the cache tag store.
`timescale 1ns / 1ps
package salc_pkg;
  localparam int ADDR_W   = 42;
  localparam int TIME_W   = 32;
  localparam int VICT_W   = 4;
  localparam int WAY_W    = 5;
  localparam int CNT_W    = 6;
  localparam int LFSR_W   = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  localparam logic [2:0] REG_SET_BITS   = 3'd0;
  localparam logic [2:0] REG_WAY_COUNT  = 3'd1;
  localparam logic [2:0] REG_REPLACE    = 3'd2;
  localparam logic [2:0] REG_SHARED     = 3'd3;
  localparam logic [2:0] REG_CORE0_WAYS = 3'd4;

  typedef struct packed {
    logic             free_found;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] lru_way;
  } eval_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic b;
    b = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {b, v[LFSR_W-1:1]};
  endfunction
endpackage

### hdl/salc_tag_ram.sv
// Single-port-write, registered-read memory holding one cache set per row.
`timescale 1ns / 1ps
module salc_tag_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

### hdl/salc_way_eval.sv
// Per-way compare logic: lookup hits, first free way and oldest-stamp search.
`timescale 1ns / 1ps
module salc_way_eval #(
  parameter int WAYS_MAX    = 16,
  parameter int TAG_WIDTH   = 42,
  parameter int STAMP_WIDTH = 32
) (
  input  logic [WAYS_MAX-1:0]                  valid_i,
  input  logic [WAYS_MAX-1:0]                  owner_i,
  input  logic [WAYS_MAX-1:0][TAG_WIDTH-1:0]   tag_i,
  input  logic [WAYS_MAX-1:0][STAMP_WIDTH-1:0] stamp_i,
  input  logic [TAG_WIDTH-1:0]                 req_tag_i,
  input  logic                                 req_core_i,
  input  logic [STAMP_WIDTH-1:0]               now_i,
  input  logic [salc_pkg::CNT_W-1:0]           lo_i,
  input  logic [salc_pkg::CNT_W-1:0]           hi_i,
  input  logic [salc_pkg::CNT_W-1:0]           wc_i,
  output logic [WAYS_MAX-1:0]                  hit_o,
  output salc_pkg::eval_t                      ev_o
);
  localparam int IW     = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
  localparam int LEAVES = 1 << IW;
  localparam int NODES  = 2 * LEAVES - 1;

  logic [NODES-1:0]       cand;
  logic [STAMP_WIDTH-1:0] key [NODES];
  logic [IW-1:0]          idx [NODES];

  always_comb begin
    logic in_rng;
    logic take_l;
    for (int i = 0; i < WAYS_MAX; i++) begin
      hit_o[i] = (salc_pkg::CNT_W'(i) < wc_i) && valid_i[i] &&
                 (owner_i[i] == req_core_i) && (tag_i[i] == req_tag_i);
    end
    ev_o.free_found = 1'b0;
    ev_o.free_way   = '0;
    for (int i = WAYS_MAX - 1; i >= 0; i--) begin
      in_rng = (salc_pkg::CNT_W'(i) >= lo_i) && (salc_pkg::CNT_W'(i) < hi_i);
      if (in_rng && !valid_i[i]) begin
        ev_o.free_found = 1'b1;
        ev_o.free_way   = salc_pkg::WAY_W'(i);
      end
    end
    // Leaves of the oldest-stamp tree; only stamps below the current time qualify.
    for (int i = 0; i < LEAVES; i++) begin
      cand[LEAVES-1+i] = 1'b0;
      key[LEAVES-1+i]  = '0;
      idx[LEAVES-1+i]  = IW'(i);
    end
    for (int i = 0; i < WAYS_MAX; i++) begin
      in_rng = (salc_pkg::CNT_W'(i) >= lo_i) && (salc_pkg::CNT_W'(i) < hi_i);
      cand[LEAVES-1+i] = in_rng && (stamp_i[i] < now_i);
      key[LEAVES-1+i]  = stamp_i[i];
    end
    // Ties go to the lower way, matching a first-found scan.
    for (int n = LEAVES - 2; n >= 0; n--) begin
      take_l = cand[2*n+1] && (!cand[2*n+2] || (key[2*n+1] <= key[2*n+2]));
      cand[n] = cand[2*n+1] || cand[2*n+2];
      key[n]  = take_l ? key[2*n+1] : key[2*n+2];
      idx[n]  = take_l ? idx[2*n+1] : idx[2*n+2];
    end
    ev_o.lru_way = cand[0] ? salc_pkg::WAY_W'(idx[0]) : salc_pkg::WAY_W'(lo_i);
  end
endmodule

### hdl/salc_lfsr_mod.sv
// Replacement LFSR with a bit-serial remainder unit for the random victim.
`timescale 1ns / 1ps
module salc_lfsr_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic                       ack_i,
  input  logic [salc_pkg::CNT_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [salc_pkg::CNT_W-1:0] rem_o
);
  localparam int CW = $clog2(salc_pkg::LFSR_W + 1);

  logic [salc_pkg::LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [salc_pkg::LFSR_W-1:0] shift_r, shift_nxt;
  logic [salc_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic [salc_pkg::CNT_W:0]    part;

  always_comb begin
    lfsr_nxt  = lfsr_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    part      = {rem_r, shift_r[salc_pkg::LFSR_W-1]};
    if (start_i) begin
      lfsr_nxt  = salc_pkg::lfsr_next(lfsr_r);
      shift_nxt = lfsr_nxt;
      rem_nxt   = '0;
      cnt_nxt   = CW'(salc_pkg::LFSR_W);
      busy_nxt  = 1'b1;
    end else if (busy_r && cnt_r != '0) begin
      // One restoring-division step per cycle, most significant bit first.
      if (part >= {1'b0, divisor_i}) begin
        part = part - {1'b0, divisor_i};
      end
      rem_nxt   = part[salc_pkg::CNT_W-1:0];
      shift_nxt = {shift_r[salc_pkg::LFSR_W-2:0], 1'b0};
      cnt_nxt   = cnt_r - 1'b1;
    end else if (ack_i) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= salc_pkg::LFSR_SEED;
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      lfsr_r <= lfsr_nxt;
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
  end

  assign done_o = busy_r && (cnt_r == '0);
  assign rem_o  = rem_r;
endmodule

### hdl/set_assoc_cache_tag_lru_partition_core.sv
// Top level of the two-core set-associative cache tag store.
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    opcode, line_address, write, core_id, time_stamp
//  out_     output     out_valid / out_ready  hit, victim_way, evicted_*
//  cfg_     input      APB write/read         set_bits, way_count, replace_random, shared_mode,
//                                             core0_ways
//
// Each item reads the whole set from the tag memory at accept; the block then compares all ways
// and, once the result register is free, writes the updated row back and loads that register.
// An install that needs a random victim first waits for the bit-serial remainder unit.
// After reset the block clears the memory one row a cycle, all MAX_SETS rows, with in_ready low.
// A result waiting in the output register does not block the next accept, only the next finish.
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lru_partition_core_macros.svh"
module set_assoc_cache_tag_lru_partition_core #(
  parameter int MAX_SETS    = 256,
  parameter int WAYS_MAX    = 16,
  parameter int TAG_WIDTH   = 42,
  parameter int STAMP_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [salc_pkg::ADDR_W-1:0] in_line_address,
  input  logic                        in_write,
  input  logic                        in_core_id,
  input  logic [salc_pkg::TIME_W-1:0] in_time_stamp,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  output logic [salc_pkg::VICT_W-1:0] out_victim_way,
  output logic                        out_evicted_valid,
  output logic                        out_evicted_dirty,
  output logic [salc_pkg::ADDR_W-1:0] out_evicted_tag,
  output logic                        out_evicted_core,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [4:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  localparam int SIW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WIW   = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
  localparam int ROW_W = WAYS_MAX * (3 + TAG_WIDTH + STAMP_WIDTH);
  localparam int CW    = salc_pkg::CNT_W;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_MOD  = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [SIW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Configuration registers.
  logic [3:0] set_bits_r;
  logic [4:0] way_count_r;
  logic       replace_random_r;
  logic       shared_mode_r;
  logic [4:0] core0_ways_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r       <= 4'd8;
      way_count_r      <= 5'd16;
      replace_random_r <= 1'b0;
      shared_mode_r    <= 1'b0;
      core0_ways_r     <= 5'd0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        salc_pkg::REG_SET_BITS:   set_bits_r       <= cfg_pwdata[3:0];
        salc_pkg::REG_WAY_COUNT:  way_count_r      <= cfg_pwdata[4:0];
        salc_pkg::REG_REPLACE:    replace_random_r <= cfg_pwdata[0];
        salc_pkg::REG_SHARED:     shared_mode_r    <= cfg_pwdata[0];
        salc_pkg::REG_CORE0_WAYS: core0_ways_r     <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      salc_pkg::REG_SET_BITS:   cfg_prdata = {28'd0, set_bits_r};
      salc_pkg::REG_WAY_COUNT:  cfg_prdata = {27'd0, way_count_r};
      salc_pkg::REG_REPLACE:    cfg_prdata = {31'd0, replace_random_r};
      salc_pkg::REG_SHARED:     cfg_prdata = {31'd0, shared_mode_r};
      salc_pkg::REG_CORE0_WAYS: cfg_prdata = {27'd0, core0_ways_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  // Request capture at accept.
  logic                   accept;
  logic [SIW-1:0]         set_idx;
  logic                   op_r, wr_r, core_r;
  logic [TAG_WIDTH-1:0]   tag_r;
  logic [STAMP_WIDTH-1:0] now_r;
  logic [SIW-1:0]         set_r;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // The set index keeps only the low set_bits address bits, folded onto the sets present.
  always_comb begin
    for (int i = 0; i < SIW; i++) begin
      set_idx[i] = in_line_address[i] && (4'(i) < set_bits_r) && (MAX_SETS > 1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      wr_r   <= in_write;
      core_r <= in_core_id;
      tag_r  <= TAG_WIDTH'(in_line_address);
      now_r  <= STAMP_WIDTH'(in_time_stamp);
      set_r  <= set_idx;
    end
  end

  // Tag memory: one row per set with every way's valid, dirty, owner, tag and stamp.
  logic                                 mem_we;
  logic [SIW-1:0]                       mem_waddr;
  logic [ROW_W-1:0]                     mem_wdata, rd_data;
  logic [WAYS_MAX-1:0]                  rd_valid, rd_dirty, rd_owner;
  logic [WAYS_MAX-1:0][TAG_WIDTH-1:0]   rd_tag;
  logic [WAYS_MAX-1:0][STAMP_WIDTH-1:0] rd_stamp;
  logic [WAYS_MAX-1:0]                  wb_valid, wb_dirty, wb_owner;
  logic [WAYS_MAX-1:0][TAG_WIDTH-1:0]   wb_tag;
  logic [WAYS_MAX-1:0][STAMP_WIDTH-1:0] wb_stamp;

  salc_tag_ram #(.DEPTH(MAX_SETS), .WIDTH(ROW_W)) u_ram (
    .clk     (clk),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (set_idx),
    .rdata_o (rd_data)
  );

  assign {rd_valid, rd_dirty, rd_owner, rd_tag, rd_stamp} = rd_data;

  // Way range of the request.
  logic [CW-1:0] wc, c0, lo, hi;
  logic          part, empty;

  always_comb begin
    if (way_count_r == 5'd0) begin
      wc = CW'(1);
    end else if ({1'b0, way_count_r} > CW'(WAYS_MAX)) begin
      wc = CW'(WAYS_MAX);
    end else begin
      wc = CW'(way_count_r);
    end
    c0    = ({1'b0, core0_ways_r} > wc) ? wc : CW'(core0_ways_r);
    part  = shared_mode_r && (core0_ways_r != 5'd0);
    lo    = (part && core_r) ? c0 : '0;
    hi    = (part && !core_r) ? c0 : wc;
    empty = (lo >= hi);
  end

  logic [WAYS_MAX-1:0] hit_vec;
  salc_pkg::eval_t     ev;

  salc_way_eval #(
    .WAYS_MAX(WAYS_MAX), .TAG_WIDTH(TAG_WIDTH), .STAMP_WIDTH(STAMP_WIDTH)
  ) u_eval (
    .valid_i    (rd_valid),
    .owner_i    (rd_owner),
    .tag_i      (rd_tag),
    .stamp_i    (rd_stamp),
    .req_tag_i  (tag_r),
    .req_core_i (core_r),
    .now_i      (now_r),
    .lo_i       (lo),
    .hi_i       (hi),
    .wc_i       (wc),
    .hit_o      (hit_vec),
    .ev_o       (ev)
  );

  // Random victim: the LFSR steps once and its value is reduced modulo the way count.
  logic          need_random, mod_start, mod_done;
  logic [CW-1:0] mod_rem;

  assign need_random = op_r && !empty && !ev.free_found && !part && replace_random_r;
  assign mod_start   = (state_r == S_RD) && need_random;

  // Finish: write the set back and load the result register.
  logic out_free, finish;
  assign out_free = !out_valid || out_ready;
  assign finish   = out_free && (((state_r == S_RD) && !need_random) ||
                                 ((state_r == S_MOD) && mod_done));

  salc_lfsr_mod u_rand (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (mod_start),
    .ack_i     (finish),
    .divisor_i (wc),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  logic [WIW-1:0] victim;
  logic           install, evict;

  assign install = op_r && !empty;
  assign evict   = install && !ev.free_found;

  always_comb begin
    if (ev.free_found) begin
      victim = WIW'(ev.free_way);
    end else if (need_random) begin
      victim = WIW'(mod_rem);
    end else begin
      victim = WIW'(ev.lru_way);
    end
  end

  always_comb begin
    wb_valid = rd_valid;
    wb_dirty = rd_dirty;
    wb_owner = rd_owner;
    wb_tag   = rd_tag;
    wb_stamp = rd_stamp;
    if (!op_r) begin
      // Every matching copy is refreshed, and a write marks each one dirty.
      for (int i = 0; i < WAYS_MAX; i++) begin
        if (hit_vec[i]) begin
          wb_stamp[i] = now_r;
          wb_dirty[i] = rd_dirty[i] || wr_r;
        end
      end
    end else if (install) begin
      wb_valid[victim] = 1'b1;
      wb_dirty[victim] = wr_r;
      wb_owner[victim] = core_r;
      wb_tag[victim]   = tag_r;
      wb_stamp[victim] = now_r;
    end
  end

  assign mem_we    = finish || (state_r == S_CLR);
  assign mem_waddr = (state_r == S_CLR) ? clr_cnt_r : set_r;
  assign mem_wdata = (state_r == S_CLR) ? '0 :
                     {wb_valid, wb_dirty, wb_owner, wb_tag, wb_stamp};

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SIW'(MAX_SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (need_random) begin
          state_nxt = S_MOD;
        end else if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      S_MOD: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Result register.
  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_hit           <= !op_r && (|hit_vec);
      out_victim_way    <= install ? salc_pkg::VICT_W'(victim) : '0;
      out_evicted_valid <= evict;
      out_evicted_dirty <= evict && rd_dirty[victim];
      out_evicted_tag   <= evict ? salc_pkg::ADDR_W'(rd_tag[victim]) : '0;
      out_evicted_core  <= evict && rd_owner[victim];
    end
  end

  // Checks.
  `SALC_ASSERT_NEXT(a_accept_reads, accept, state_r == S_RD)
  `SALC_ASSERT_NEXT(a_finish_loads, finish, out_valid_r)
  `SALC_ASSERT_SAME(a_done_in_mod, mod_done, state_r == S_MOD)
  `SALC_ASSERT_SAME(a_no_accept_clr, state_r == S_CLR, !in_ready && !finish)
endmodule
